[src/c2pu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pu_pkg
// Types and constants shared by the 2bpp pixel unpacker modules.
// ----------------------------------------------------------------------------
package c2pu_pkg;

    localparam int XY_W        = 11;
    localparam int COORD_BITS  = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 22;
    localparam int PIX_PER_BYTE = 4;
    localparam int Q_DEPTH     = 2;

    // Screen coordinates wrap at COORD_BITS, then fit the output field.
    localparam logic [XY_W-1:0] COORD_MASK = XY_W'((1 << COORD_BITS) - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 3'd0,
        REG_IMAGE_HEIGHT  = 3'd1,
        REG_ORIGIN_X      = 3'd2,
        REG_ORIGIN_Y      = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_STRIP_MODE    = 3'd6,
        REG_STRIP_BAND    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        STRIP_NONE          = 3'd0,
        STRIP_LAND_CCW      = 3'd1,
        STRIP_LAND_CW       = 3'd2,
        STRIP_PORTRAIT      = 3'd3,
        STRIP_PORTRAIT_INV  = 3'd4
    } strip_mode_t;

    typedef struct packed {
        logic [10:0]        image_width;
        logic [10:0]        image_height;
        logic signed [11:0] origin_x;
        logic signed [11:0] origin_y;
        logic [10:0]        screen_width;
        logic [10:0]        screen_height;
        logic [2:0]         strip_mode;
        logic [21:0]        strip_band;
    } cfg_t;

    typedef struct packed {
        logic [XY_W-1:0] left;
        logic [XY_W-1:0] right;
        logic [XY_W-1:0] top;
        logic [XY_W-1:0] bottom;
    } window_t;

    // One classified byte waiting for the back end.
    typedef struct packed {
        logic [7:0]              pixels;
        logic [PIX_PER_BYTE-1:0] mask;
        logic [XY_W-1:0]         x_base;
        logic [XY_W-1:0]         y;
    } q_entry_t;

endpackage

[src/c2pu_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pu_cfg
// Configuration registers and the derived image-local clip window.
// ----------------------------------------------------------------------------
module c2pu_cfg
    import c2pu_pkg::*;
#(
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg,
    output window_t                window,
    output logic                   cfg_busy
);

    cfg_t    cfg_reg, cfg_next;
    window_t window_reg, window_next;
    logic    busy_reg;

    logic signed [13:0] ox, oy, iw, ih, sw, sh, s0, s1, h;
    logic signed [13:0] x0, x1, y0, y1;

    function automatic logic signed [13:0] mx(input logic signed [13:0] a,
                                              input logic signed [13:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [13:0] mn(input logic signed [13:0] a,
                                              input logic signed [13:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [XY_W-1:0] sat11(input logic signed [13:0] v);
        logic [XY_W-1:0] r;
        if (v < 14'sd0) begin
            r = '0;
        end else if (v > 14'sd2047) begin
            r = 11'd2047;
        end else begin
            r = v[XY_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_IMAGE_WIDTH:   cfg_next.image_width   = cfg_data[10:0];
                REG_IMAGE_HEIGHT:  cfg_next.image_height  = cfg_data[10:0];
                REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[11:0];
                REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[11:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[10:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[10:0];
                REG_STRIP_MODE:    cfg_next.strip_mode    = cfg_data[2:0];
                REG_STRIP_BAND:    cfg_next.strip_band    = cfg_data[21:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // The window is registered from the configuration registers, so it follows them in the next cycle.
    always_comb begin
        ox = {{2{cfg_reg.origin_x[11]}}, cfg_reg.origin_x};
        oy = {{2{cfg_reg.origin_y[11]}}, cfg_reg.origin_y};
        iw = {3'b000, cfg_reg.image_width};
        ih = {3'b000, cfg_reg.image_height};
        sw = {3'b000, cfg_reg.screen_width};
        sh = {3'b000, cfg_reg.screen_height};
        s0 = {3'b000, cfg_reg.strip_band[10:0]};
        s1 = s0 + {3'b000, cfg_reg.strip_band[21:11]};
        h  = 14'(PANEL_HEIGHT);

        x0 = mx(14'sd0, -ox);
        y0 = mx(14'sd0, -oy);
        x1 = mn(iw, sw - ox);
        y1 = mn(ih, sh - oy);

        case (strip_mode_t'(cfg_reg.strip_mode))
            STRIP_LAND_CCW: begin
                y0 = mx(y0, s0 - oy);
                y1 = mn(y1, s1 - oy);
            end
            STRIP_LAND_CW: begin
                y0 = mx(y0, h - s1 - oy);
                y1 = mn(y1, h - s0 - oy);
            end
            STRIP_PORTRAIT: begin
                x0 = mx(x0, h - s1 - ox);
                x1 = mn(x1, h - s0 - ox);
            end
            STRIP_PORTRAIT_INV: begin
                x0 = mx(x0, s0 - ox);
                x1 = mn(x1, s1 - ox);
            end
            default: begin
            end
        endcase

        window_next.left   = sat11(x0);
        window_next.right  = sat11(x1);
        window_next.top    = sat11(y0);
        window_next.bottom = sat11(y1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width   <= 11'd1;
            cfg_reg.image_height  <= 11'd1;
            cfg_reg.origin_x      <= '0;
            cfg_reg.origin_y      <= '0;
            cfg_reg.screen_width  <= 11'd800;
            cfg_reg.screen_height <= 11'd480;
            cfg_reg.strip_mode    <= STRIP_NONE;
            cfg_reg.strip_band    <= '0;
            window_reg.left       <= '0;
            window_reg.right      <= 11'd1;
            window_reg.top        <= '0;
            window_reg.bottom     <= 11'd1;
            busy_reg              <= 1'b0;
        end else begin
            cfg_reg    <= cfg_next;
            window_reg <= window_next;
            busy_reg   <= cfg_we;
        end
    end

    assign cfg      = cfg_reg;
    assign window   = window_reg;
    assign cfg_busy = busy_reg;

endmodule

[src/c2pu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pu_front
// Accepts packed bytes, tracks the image position and marks visible pixels.
// ----------------------------------------------------------------------------
module c2pu_front
    import c2pu_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_packed_byte,
    input  cfg_t       cfg,
    input  window_t    window,
    input  logic       cfg_busy,
    input  logic       cfg_we,
    input  logic       q_full,
    output logic       q_push,
    output q_entry_t   q_data
);

    logic [8:0]  byte_in_row_reg, byte_in_row_next;
    logic [10:0] row_index_reg, row_index_next;

    logic                    accept;
    logic                    row_vis;
    logic [XY_W-1:0]         col0;
    logic [XY_W-1:0]         col;
    logic [PIX_PER_BYTE-1:0] mask;
    logic [9:0]              bpr;
    logic [11:0]             bpr_sum;

    assign s_ready = !cfg_busy && !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        col0    = {byte_in_row_reg, 2'b00};
        row_vis = (row_index_reg >= window.top) && (row_index_reg < window.bottom);
        for (int k = 0; k < PIX_PER_BYTE; k++) begin
            col     = col0 + XY_W'(k);
            mask[k] = row_vis && (col < cfg.image_width) && (col >= window.left)
                      && (col < window.right);
        end
    end

    assign q_push        = accept && (|mask);
    assign q_data.pixels = s_packed_byte;
    assign q_data.mask   = mask;
    assign q_data.x_base = cfg.origin_x[XY_W-1:0] + col0;
    assign q_data.y      = cfg.origin_y[XY_W-1:0] + row_index_reg;

    always_comb begin
        bpr_sum          = {1'b0, cfg.image_width} + 12'd3;
        bpr              = bpr_sum[11:2];
        byte_in_row_next = byte_in_row_reg;
        row_index_next   = row_index_reg;
        if (cfg_we) begin
            byte_in_row_next = '0;
            row_index_next   = '0;
        end else if (accept) begin
            if ({1'b0, byte_in_row_reg} + 10'd1 >= bpr) begin
                byte_in_row_next = '0;
                if ({1'b0, row_index_reg} + 12'd1 >= {1'b0, cfg.image_height}) begin
                    row_index_next = '0;
                end else begin
                    row_index_next = row_index_reg + 11'd1;
                end
            end else begin
                byte_in_row_next = byte_in_row_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_row_reg <= '0;
            row_index_reg   <= '0;
        end else begin
            byte_in_row_reg <= byte_in_row_next;
            row_index_reg   <= row_index_next;
        end
    end

endmodule

[src/c2pu_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pu_queue
// Short queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module c2pu_queue
    import c2pu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_data,
    input  logic     pop,
    output q_entry_t head,
    output logic     full,
    output logic     empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    q_entry_t          entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/c2pu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2pu_back
// Emits the visible pixels of the queued byte, one a cycle while m_ready does not
// stall it, into the output register.
// ----------------------------------------------------------------------------
module c2pu_back
    import c2pu_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  q_entry_t        head,
    input  logic            q_empty,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XY_W-1:0] m_screen_x,
    output logic [XY_W-1:0] m_screen_y,
    output logic [1:0]      m_gray_level,
    output logic            m_last_of_byte
);

    logic [PIX_PER_BYTE-1:0] done_reg, done_next;
    logic                    valid_reg, valid_next;
    logic [XY_W-1:0]         x_reg, x_next;
    logic [XY_W-1:0]         y_reg, y_next;
    logic [1:0]              gray_reg, gray_next;
    logic                    last_reg, last_next;

    logic                    advance;
    logic [PIX_PER_BYTE-1:0] pending;
    logic [PIX_PER_BYTE-1:0] sel_bit;
    logic [1:0]              sel;
    logic                    is_last;

    assign advance = !valid_reg || m_ready;
    assign pending = head.mask & ~done_reg;

    // Leftmost remaining pixel goes first.
    always_comb begin
        sel = '0;
        for (int k = PIX_PER_BYTE - 1; k >= 0; k--) begin
            if (pending[k]) begin
                sel = 2'(k);
            end
        end
        sel_bit = PIX_PER_BYTE'(1) << sel;
        is_last = ((pending & ~sel_bit) == '0);
    end

    always_comb begin
        done_next  = done_reg;
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        gray_next  = gray_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        if (advance) begin
            valid_next = !q_empty;
            if (!q_empty) begin
                x_next    = (head.x_base + XY_W'(sel)) & COORD_MASK;
                y_next    = head.y & COORD_MASK;
                gray_next = head.pixels[3'd6 - {sel, 1'b0} +: 2];
                last_next = is_last;
                if (is_last) begin
                    q_pop     = 1'b1;
                    done_next = '0;
                end else begin
                    done_next = done_reg | sel_bit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg  <= done_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        gray_reg <= gray_next;
        last_reg <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_screen_x     = x_reg;
    assign m_screen_y     = y_reg;
    assign m_gray_level   = gray_reg;
    assign m_last_of_byte = last_reg;

endmodule

[src/clipped_2bpp_pixel_unpacker.sv]
`timescale 1ns / 1ps
// With the back end idle, an accepted byte is written into the queue and its first
// visible pixel is then loaded from the queue head into the output register.
// Throughput: one pixel per cycle from the single output register while m_ready does
// not stall it; a byte yields as many pixels as it has visible (0 to 4). Bytes with no
// visible pixel are taken one per cycle while the queue has room and cfg_busy is low.
// Reset: registers return to their reset values and the image position to zero;
// after any register write, input is held off for one cycle while the window updates.
// ----------------------------------------------------------------------------
// clipped_2bpp_pixel_unpacker
// Unpacks 2bpp image bytes into clipped screen pixels with coordinates.
// ----------------------------------------------------------------------------
module clipped_2bpp_pixel_unpacker
    import c2pu_pkg::*;
#(
    parameter int PANEL_HEIGHT = 480
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_packed_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [XY_W-1:0]        m_screen_x,
    output logic [XY_W-1:0]        m_screen_y,
    output logic [1:0]             m_gray_level,
    output logic                   m_last_of_byte
);

    cfg_t     cfg;
    window_t  window;
    logic     cfg_busy;
    logic     q_push, q_pop, q_full, q_empty;
    q_entry_t q_in, q_head;

    c2pu_cfg #(
        .PANEL_HEIGHT(PANEL_HEIGHT)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .cfg      (cfg),
        .window   (window),
        .cfg_busy (cfg_busy)
    );

    c2pu_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_packed_byte(s_packed_byte),
        .cfg          (cfg),
        .window       (window),
        .cfg_busy     (cfg_busy),
        .cfg_we       (cfg_we),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    c2pu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    c2pu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_screen_x    (m_screen_x),
        .m_screen_y    (m_screen_y),
        .m_gray_level  (m_gray_level),
        .m_last_of_byte(m_last_of_byte)
    );

endmodule
